FILE: design/qsu_pkg.sv
// qsu_pkg: types, character constants and lookup functions for the
// quoted string unescape block; no dependencies
`timescale 1ns / 1ps

package qsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_TEXT = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_OCT  = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5
    } mode_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] OCT_MAX   = 8'hff;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] oct_value;
        logic [1:0] oct_digits;
        logic [3:0] hex_hi;
    } dec_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // {hit, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f")
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F")
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // {hit, decoded byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3f:   r = {1'b1, 8'h3f};
            8'h5c:   r = {1'b1, 8'h5c};
            "a":     r = {1'b1, 8'h07};
            "b":     r = {1'b1, 8'h08};
            "f":     r = {1'b1, 8'h0c};
            "n":     r = {1'b1, 8'h0a};
            "r":     r = {1'b1, 8'h0d};
            "t":     r = {1'b1, 8'h09};
            "v":     r = {1'b1, 8'h0b};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/qsu_decode.sv
// qsu_decode: combinational decode of one character against the current
// literal state, giving the next state and up to two result words; uses qsu_pkg
`timescale 1ns / 1ps

module qsu_decode (
    input  logic [7:0]          char_in,
    input  logic                start_req,
    input  qsu_pkg::dec_state_t cur,
    output qsu_pkg::dec_state_t nxt,
    output logic [1:0]          num,
    output qsu_pkg::result_t    res0,
    output qsu_pkg::result_t    res1
);
    import qsu_pkg::*;

    logic        txt_emit;
    logic [1:0]  txt_kind;
    logic [7:0]  txt_data;
    mode_t       txt_mode;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic        is_oct;
    logic [10:0] oct_ext;
    logic [1:0]  oct_cnt;

    assign hex     = hex_digit(char_in);
    assign esc     = simple_escape(char_in);
    assign is_oct  = (char_in >= "0") && (char_in <= "7");
    assign oct_ext = {cur.oct_value, char_in[2:0]};
    assign oct_cnt = cur.oct_digits + 2'd1;

    // plain text handling, shared by text mode and the octal terminator
    always_comb
    begin
        txt_emit = 1'b1;
        txt_kind = KIND_BYTE;
        txt_data = char_in;
        txt_mode = MODE_TEXT;
        if (char_in == CH_NUL)
        begin
            txt_kind = KIND_ERR;
            txt_data = 8'd0;
            txt_mode = MODE_IDLE;
        end
        else if (char_in == CH_QUOTE)
        begin
            txt_kind = KIND_END;
            txt_data = 8'd0;
            txt_mode = MODE_IDLE;
        end
        else if (char_in == CH_BSLASH)
        begin
            txt_emit = 1'b0;
            txt_mode = MODE_ESC;
        end
    end

    always_comb
    begin
        nxt  = cur;
        num  = 2'd0;
        res0 = '0;
        res1 = '0;
        if (start_req)
        begin
            nxt.oct_value  = 8'd0;
            nxt.oct_digits = 2'd0;
            nxt.hex_hi     = 4'd0;
            if (char_in == CH_QUOTE)
                nxt.mode = MODE_TEXT;
            else
            begin
                nxt.mode  = MODE_IDLE;
                num       = 2'd1;
                res0.kind = KIND_ERR;
            end
        end
        else
        begin
            case (cur.mode)
                MODE_TEXT:
                begin
                    nxt.mode = txt_mode;
                    if (txt_emit)
                    begin
                        num       = 2'd1;
                        res0.kind = txt_kind;
                        res0.data = txt_data;
                    end
                end
                MODE_ESC:
                begin
                    if (is_oct)
                    begin
                        nxt.oct_value  = {5'd0, char_in[2:0]};
                        nxt.oct_digits = 2'd1;
                        nxt.mode       = MODE_OCT;
                    end
                    else if (char_in == CH_X)
                        nxt.mode = MODE_HEX1;
                    else if (esc[8])
                    begin
                        num       = 2'd1;
                        res0.kind = KIND_BYTE;
                        res0.data = esc[7:0];
                        nxt.mode  = MODE_TEXT;
                    end
                    else
                    begin
                        num       = 2'd1;
                        res0.kind = KIND_ERR;
                        nxt.mode  = MODE_IDLE;
                    end
                end
                MODE_OCT:
                begin
                    if (is_oct && oct_ext <= {3'd0, OCT_MAX})
                    begin
                        nxt.oct_value  = oct_ext[7:0];
                        nxt.oct_digits = oct_cnt;
                        if (oct_cnt == 2'd3)
                        begin
                            num            = 2'd1;
                            res0.kind      = KIND_BYTE;
                            res0.data      = oct_ext[7:0];
                            nxt.mode       = MODE_TEXT;
                            nxt.oct_value  = 8'd0;
                            nxt.oct_digits = 2'd0;
                        end
                    end
                    else
                    begin
                        // flush the octal byte, then treat the character as text
                        num            = 2'd1;
                        res0.kind      = KIND_BYTE;
                        res0.data      = cur.oct_value;
                        nxt.oct_value  = 8'd0;
                        nxt.oct_digits = 2'd0;
                        nxt.mode       = txt_mode;
                        if (txt_emit)
                        begin
                            num       = 2'd2;
                            res1.kind = txt_kind;
                            res1.data = txt_data;
                        end
                    end
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    if (!hex[4])
                    begin
                        num       = 2'd1;
                        res0.kind = KIND_ERR;
                        nxt.mode  = MODE_IDLE;
                    end
                    else if (cur.mode == MODE_HEX1)
                    begin
                        nxt.hex_hi = hex[3:0];
                        nxt.mode   = MODE_HEX2;
                    end
                    else
                    begin
                        num       = 2'd1;
                        res0.kind = KIND_BYTE;
                        res0.data = {cur.hex_hi, hex[3:0]};
                        nxt.mode  = MODE_TEXT;
                    end
                end
                default:
                begin
                    nxt.mode  = MODE_IDLE;
                    num       = 2'd1;
                    res0.kind = KIND_ERR;
                end
            endcase
        end
        if (num == 2'd1)
            res0.last = 1'b1;
        if (num == 2'd2)
            res1.last = 1'b1;
    end

endmodule

FILE: design/quoted_string_unescape_core.sv
// quoted_string_unescape_core: top level, input register, literal state,
// two-word result register; uses qsu_pkg and qsu_decode
//
// Decodes a double-quoted C-style literal one character per word. A character
// is taken into an input register, decoded by a single pass of logic against
// the literal state, and its results (none, one or two) land in a two-slot
// result register that drains one word per cycle while res_ready is high.
// The block sustains one character per cycle while res_ready is high; a
// character that yields two results (an octal escape closed by any character
// other than a backslash) holds the result port for both words, so the input
// stalls until the first is taken. src_ready follows res_ready combinationally.
`timescale 1ns / 1ps

module quoted_string_unescape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_ready,
    input  logic [7:0] char_in,
    input  logic       start_req,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] kind,
    output logic [7:0] byte_out,
    output logic       last
);
    import qsu_pkg::*;

    logic       a_vld_reg, a_vld_next;
    logic [7:0] a_char_reg;
    logic       a_start_reg;
    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    dec_state_t state_reg, state_next;

    dec_state_t dec_nxt;
    logic [1:0] dec_num;
    result_t    dec_r0, dec_r1;
    logic       b_free, a_move, src_acc, res_acc;

    qsu_decode u_decode (
        .char_in   (a_char_reg),
        .start_req (a_start_reg),
        .cur       (state_reg),
        .nxt       (dec_nxt),
        .num       (dec_num),
        .res0      (dec_r0),
        .res1      (dec_r1)
    );

    assign res_acc   = res_valid && res_ready;
    assign b_free    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && res_ready);
    assign a_move    = a_vld_reg && b_free;
    assign src_ready = !a_vld_reg || b_free;
    assign src_acc   = src_valid && src_ready;

    always_comb
    begin
        a_vld_next = a_vld_reg;
        if (src_acc)
            a_vld_next = 1'b1;
        else if (a_move)
            a_vld_next = 1'b0;
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        state_next = state_reg;
        if (a_move)
        begin
            cnt_next   = dec_num;
            slot0_next = dec_r0;
            slot1_next = dec_r1;
            state_next = dec_nxt;
        end
        else if (res_acc)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            cnt_reg   <= 2'd0;
            state_reg <= '{mode: MODE_IDLE, oct_value: 8'd0, oct_digits: 2'd0, hex_hi: 4'd0};
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            cnt_reg   <= cnt_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_acc)
        begin
            a_char_reg  <= char_in;
            a_start_reg <= start_req;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign res_valid = (cnt_reg != 2'd0);
    assign kind      = slot0_reg.kind;
    assign byte_out  = slot0_reg.data;
    assign last      = slot0_reg.last;

endmodule

FILE: design/qsu_checker.sv
// qsu_checker: port-level assertions for quoted_string_unescape_core and the
// bind that attaches them; uses qsu_pkg
`timescale 1ns / 1ps

module qsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       src_valid,
    input logic       src_ready,
    input logic [7:0] char_in,
    input logic       start_req,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] kind,
    input logic [7:0] byte_out,
    input logic       last
);
    import qsu_pkg::*;

    // a stalled input word holds
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_ready |=> src_valid && $stable(char_in) && $stable(start_req))
        else $error("input word changed while stalled");

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(byte_out)
            && $stable(last))
        else $error("result word changed while stalled");

    // end and error words carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_BYTE |-> byte_out == 8'd0)
        else $error("nonzero byte on end or error word");

    // end and error are always the final word of their character
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_END || kind == KIND_ERR) |-> last)
        else $error("end or error word not marked last");

    // a word without last is followed by the second word at once
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last |=> res_valid)
        else $error("second word of a pair missing");

endmodule

bind quoted_string_unescape_core qsu_checker u_qsu_checker (.*);
